/* src/hsvc_pkg.sv */
package hsvc_pkg;

  localparam int unsigned CH_W = 16;
  localparam logic [CH_W-1:0] ONE_Q15 = 16'd32768;

  // hue in 1/64 degree: one 60-degree sector is 3840 units, full circle 23040
  localparam int unsigned HUE_W = 15;
  localparam int unsigned REM_W = 12;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

  // D = 32768 * 3840 = 15 * 2^23
  localparam int unsigned PROD_W = 27;
  localparam int unsigned NUM_W = 42;
  localparam int unsigned DEN_SHIFT = 23;
  localparam int unsigned QUO_W = NUM_W - DEN_SHIFT;
  localparam logic [PROD_W-1:0] FRAC_DENOM = 27'd125829120;
  localparam logic [NUM_W-1:0] DENOM_HALF = 42'd62914560;

  // floor(2^23 / 15); the estimate is low by at most one
  localparam int unsigned RCP_W = 20;
  localparam logic [RCP_W-1:0] RECIP15 = 20'd559240;
  localparam logic [QUO_W:0] DIV15 = 20'd15;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic y_en;
    logic q_en;
  } div_adv_t;

endpackage

/* src/hsvc_round_div.sv */
// floor((num + D/2) / D) with D = 15 * 2^23, over two register stages
module hsvc_round_div import hsvc_pkg::*; (
  input  logic             clk,
  input  div_adv_t         adv,
  input  logic [NUM_W-1:0] num,
  output logic [CH_W-1:0]  quo
);

  logic [NUM_W-1:0]       sum;
  logic [QUO_W-1:0]       y_nxt;
  logic [QUO_W-1:0]       y_r;
  logic [QUO_W-1:0]       y2_r;
  logic [QUO_W+RCP_W-1:0] prod;
  logic [CH_W-1:0]        q0_nxt;
  logic [CH_W-1:0]        q0_r;
  logic [QUO_W:0]         mul15;
  logic [QUO_W:0]         rem;

  assign sum   = num + DENOM_HALF;
  assign y_nxt = sum[NUM_W-1:DEN_SHIFT];

  assign prod   = {{RCP_W{1'b0}}, y_r} * {{QUO_W{1'b0}}, RECIP15};
  assign q0_nxt = prod[DEN_SHIFT +: CH_W];

  always_ff @(posedge clk) begin
    if (adv.y_en) begin
      y_r <= y_nxt;
    end
    if (adv.q_en) begin
      q0_r <= q0_nxt;
      y2_r <= y_r;
    end
  end

  // remainder against 15 * q0 is 0..29, one correction step
  assign mul15 = {q0_r, 4'b0000} - {{(QUO_W+1-CH_W){1'b0}}, q0_r};
  assign rem   = {1'b0, y2_r} - mul15;
  assign quo   = (rem >= DIV15) ? q0_r + 16'd1 : q0_r;

endmodule

/* src/hsv_to_rgb_pixel_convert.sv */
// Channel  Direction  Handshake               Payload
// in_      input      in_valid / in_stall     hue (s16), saturation, brightness, alpha_in
// out_     output     out_valid / out_stall   red, green, blue, alpha_out
//
// One pixel per clock sustained while out_stall is low; each pixel passes through the multiplier
// chain in order: sector split, s*f products, subtract, v*(D-s*f),
// round and shift, reciprocal multiply by 1/15, remainder correction and channel mux.
// Synchronous reset clears only the stage valid bits.
// A stall holds each occupied stage; empty stages keep filling, so in_stall rises
// only when all seven stages hold a pixel and out_stall is high.
module hsv_to_rgb_pixel_convert import hsvc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [CH_W-1:0] in_hue,
  input  logic [CH_W-1:0]        in_saturation,
  input  logic [CH_W-1:0]        in_brightness,
  input  logic [CH_W-1:0]        in_alpha_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CH_W-1:0]        out_red,
  output logic [CH_W-1:0]        out_green,
  output logic [CH_W-1:0]        out_blue,
  output logic [CH_W-1:0]        out_alpha_out
);

  localparam int unsigned NSTG = 7;

  typedef struct packed {
    logic            neg;
    sector_t         sec;
    logic [CH_W-1:0] v;
    logic [CH_W-1:0] a;
  } side_t;

  function automatic logic [CH_W-1:0] sat_one(input logic [CH_W-1:0] x);
    return (x > ONE_Q15) ? ONE_Q15 : x;
  endfunction

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = !out_stall;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign vld_nxt = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (vld_nxt & rdy[NSTG-1:0]) | (vld_r & ~rdy[NSTG-1:0]);
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

  // stage 0: wrap, sector split, input saturation
  logic [HUE_W-1:0] hue_w;
  logic [HUE_W-1:0] hue_base;
  logic [HUE_W-1:0] hue_diff;
  sector_t          sec_nxt;
  side_t            side0_nxt;
  side_t            side0_r;
  logic [CH_W-1:0]  s0_r;
  logic [REM_W-1:0] rem0_r;

  assign hue_w = (in_hue[HUE_W-1:0] >= HUE_FULL) ? '0 : in_hue[HUE_W-1:0];

  always_comb begin
    if (hue_w >= HUE_SECTOR * 15'd5) begin
      sec_nxt  = SEC_M_TO_R;
      hue_base = HUE_SECTOR * 15'd5;
    end else if (hue_w >= HUE_SECTOR * 15'd4) begin
      sec_nxt  = SEC_B_TO_M;
      hue_base = HUE_SECTOR * 15'd4;
    end else if (hue_w >= HUE_SECTOR * 15'd3) begin
      sec_nxt  = SEC_C_TO_B;
      hue_base = HUE_SECTOR * 15'd3;
    end else if (hue_w >= HUE_SECTOR * 15'd2) begin
      sec_nxt  = SEC_G_TO_C;
      hue_base = HUE_SECTOR * 15'd2;
    end else if (hue_w >= HUE_SECTOR) begin
      sec_nxt  = SEC_Y_TO_G;
      hue_base = HUE_SECTOR;
    end else begin
      sec_nxt  = SEC_R_TO_Y;
      hue_base = '0;
    end
  end

  assign hue_diff = hue_w - hue_base;

  always_comb begin
    side0_nxt.neg = in_hue[CH_W-1];
    side0_nxt.sec = sec_nxt;
    side0_nxt.v   = sat_one(in_brightness);
    side0_nxt.a   = sat_one(in_alpha_in);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side0_r <= side0_nxt;
      s0_r    <= sat_one(in_saturation);
      rem0_r  <= hue_diff[REM_W-1:0];
    end
  end

  // stage 1: s*r, s*(3840-r), v*(1-s)
  logic [REM_W-1:0]       trem;
  logic [CH_W-1:0]        one_m_s;
  logic [CH_W+REM_W-1:0]  sr_full;
  logic [CH_W+REM_W-1:0]  st_full;
  logic [2*CH_W-1:0]      pp_nxt;
  side_t                  side1_r;
  logic [PROD_W-1:0]      sr1_r;
  logic [PROD_W-1:0]      st1_r;
  logic [2*CH_W-1:0]      pp1_r;

  assign trem    = HUE_SECTOR[REM_W-1:0] - rem0_r;
  assign one_m_s = ONE_Q15 - s0_r;
  assign sr_full = {{REM_W{1'b0}}, s0_r} * {{CH_W{1'b0}}, rem0_r};
  assign st_full = {{REM_W{1'b0}}, s0_r} * {{CH_W{1'b0}}, trem};
  assign pp_nxt  = {{CH_W{1'b0}}, side0_r.v} * {{CH_W{1'b0}}, one_m_s};

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side1_r <= side0_r;
      sr1_r   <= sr_full[PROD_W-1:0];
      st1_r   <= st_full[PROD_W-1:0];
      pp1_r   <= pp_nxt;
    end
  end

  // stage 2: D - s*r, D - s*(3840-r), rounded P
  logic [2*CH_W-1:0] pp_rnd;
  side_t             side2_r;
  logic [PROD_W-1:0] dq2_r;
  logic [PROD_W-1:0] dt2_r;
  logic [CH_W-1:0]   p2_r;

  assign pp_rnd = pp1_r + 32'd16384;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      side2_r <= side1_r;
      dq2_r   <= FRAC_DENOM - sr1_r;
      dt2_r   <= FRAC_DENOM - st1_r;
      p2_r    <= pp_rnd[2*CH_W-2:CH_W-1];
    end
  end

  // stage 3: v * (D - ...)
  side_t            side3_r;
  logic [CH_W-1:0]  p3_r;
  logic [NUM_W-1:0] nq3_r;
  logic [NUM_W-1:0] nt3_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      side3_r <= side2_r;
      p3_r    <= p2_r;
      nq3_r   <= {{(NUM_W-CH_W){1'b0}}, side2_r.v} * {{(NUM_W-PROD_W){1'b0}}, dq2_r};
      nt3_r   <= {{(NUM_W-CH_W){1'b0}}, side2_r.v} * {{(NUM_W-PROD_W){1'b0}}, dt2_r};
    end
  end

  // stages 4 and 5: rounded divide by D inside the divider units
  div_adv_t        div_adv;
  logic [CH_W-1:0] q_q;
  logic [CH_W-1:0] q_t;
  side_t           side4_r;
  side_t           side5_r;
  logic [CH_W-1:0] p4_r;
  logic [CH_W-1:0] p5_r;

  assign div_adv.y_en = rdy[4];
  assign div_adv.q_en = rdy[5];

  hsvc_round_div u_div_q (
    .clk (clk),
    .adv (div_adv),
    .num (nq3_r),
    .quo (q_q)
  );

  hsvc_round_div u_div_t (
    .clk (clk),
    .adv (div_adv),
    .num (nt3_r),
    .quo (q_t)
  );

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      side4_r <= side3_r;
      p4_r    <= p3_r;
    end
    if (rdy[5]) begin
      side5_r <= side4_r;
      p5_r    <= p4_r;
    end
  end

  // stage 6: channel order by sector
  logic [CH_W-1:0] red_sel;
  logic [CH_W-1:0] green_sel;
  logic [CH_W-1:0] blue_sel;

  always_comb begin
    case (side5_r.sec)
      SEC_R_TO_Y: begin
        red_sel = side5_r.v; green_sel = q_t;       blue_sel = p5_r;
      end
      SEC_Y_TO_G: begin
        red_sel = q_q;       green_sel = side5_r.v; blue_sel = p5_r;
      end
      SEC_G_TO_C: begin
        red_sel = p5_r;      green_sel = side5_r.v; blue_sel = q_t;
      end
      SEC_C_TO_B: begin
        red_sel = p5_r;      green_sel = q_q;       blue_sel = side5_r.v;
      end
      SEC_B_TO_M: begin
        red_sel = q_t;       green_sel = p5_r;      blue_sel = side5_r.v;
      end
      default: begin
        red_sel = side5_r.v; green_sel = p5_r;      blue_sel = q_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      out_red       <= side5_r.neg ? '0 : red_sel;
      out_green     <= side5_r.neg ? '0 : green_sel;
      out_blue      <= side5_r.neg ? '0 : blue_sel;
      out_alpha_out <= side5_r.a;
    end
  end

  a_rst_clears: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("pipeline valid bits not cleared by reset");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (q_q <= side5_r.v) && (q_t <= side5_r.v))
    else $error("Q or T above brightness");

  a_p_lowest: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (p5_r <= q_q) && (p5_r <= q_t))
    else $error("P above Q or T");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= ONE_Q15) && (out_green <= ONE_Q15) && (out_blue <= ONE_Q15))
    else $error("output channel above 1.0");

endmodule

/* sim/testbench.sv */
module testbench;
  import hsvc_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam longint unsigned SECTOR_UNITS = 3840;
  localparam longint unsigned FULL_TURN = 23040;
  localparam longint unsigned UNITY = 32768;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } rgba_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [CH_W-1:0] in_hue = '0;
  logic [CH_W-1:0]        in_saturation = '0;
  logic [CH_W-1:0]        in_brightness = '0;
  logic [CH_W-1:0]        in_alpha_in = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CH_W-1:0]        out_red;
  logic [CH_W-1:0]        out_green;
  logic [CH_W-1:0]        out_blue;
  logic [CH_W-1:0]        out_alpha_out;

  rgba_t expected_pixels[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    pixel_mismatches = 0;
  int    pixels_checked = 0;
  int    pixels_sent = 0;

  hsv_to_rgb_pixel_convert i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .in_alpha_in  (in_alpha_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha_out(out_alpha_out)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned clamp_unity(logic [CH_W-1:0] x);
    return (x > UNITY) ? UNITY : longint'(x);
  endfunction

  function automatic rgba_t predict_rgba(logic [CH_W-1:0] hue, logic [CH_W-1:0] sat_raw,
                                         logic [CH_W-1:0] val_raw, logic [CH_W-1:0] alpha_raw);
    rgba_t           px;
    longint unsigned s, v, h, rem, p, q, t, denom;
    sector_t         sec;
    s = clamp_unity(sat_raw);
    v = clamp_unity(val_raw);
    px.alpha = 16'(clamp_unity(alpha_raw));
    px.red = '0;
    px.green = '0;
    px.blue = '0;
    // negative hue: black, alpha still passes
    if (!hue[CH_W-1]) begin
      h = 64'(hue);
      if (h >= FULL_TURN) h = 0;
      sec = sector_t'(3'(h / SECTOR_UNITS));
      rem = h % SECTOR_UNITS;
      denom = UNITY * SECTOR_UNITS;
      p = (v * (UNITY - s) + UNITY / 2) / UNITY;
      q = (v * (denom - s * rem) + denom / 2) / denom;
      t = (v * (denom - s * (SECTOR_UNITS - rem)) + denom / 2) / denom;
      case (sec)
        SEC_R_TO_Y: begin px.red = 16'(v); px.green = 16'(t); px.blue = 16'(p); end
        SEC_Y_TO_G: begin px.red = 16'(q); px.green = 16'(v); px.blue = 16'(p); end
        SEC_G_TO_C: begin px.red = 16'(p); px.green = 16'(v); px.blue = 16'(t); end
        SEC_C_TO_B: begin px.red = 16'(p); px.green = 16'(q); px.blue = 16'(v); end
        SEC_B_TO_M: begin px.red = 16'(t); px.green = 16'(p); px.blue = 16'(v); end
        default: begin px.red = 16'(v); px.green = 16'(p); px.blue = 16'(q); end
      endcase
    end
    return px;
  endfunction

  task automatic check_channel(string name, logic [CH_W-1:0] exp_v, logic [CH_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      pixel_mismatches++;
    end
  endtask

  // predict on input transactions, check on output transactions
  always @(posedge clk) begin
    rgba_t exp_px;
    if (rst_n && in_valid && !in_stall)
      expected_pixels.push_back(predict_rgba(in_hue, in_saturation, in_brightness, in_alpha_in));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: red %0d green %0d blue %0d alpha %0d",
               out_red, out_green, out_blue, out_alpha_out);
        pixel_mismatches++;
      end else begin
        exp_px = expected_pixels.pop_front();
        check_channel("red", exp_px.red, out_red);
        check_channel("green", exp_px.green, out_green);
        check_channel("blue", exp_px.blue, out_blue);
        check_channel("alpha_out", exp_px.alpha, out_alpha_out);
        pixels_checked++;
      end
    end
  end

  always @(posedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_pixel(logic [CH_W-1:0] h, logic [CH_W-1:0] s, logic [CH_W-1:0] v,
                            logic [CH_W-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hue <= h;
    in_saturation <= s;
    in_brightness <= v;
    in_alpha_in <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // hold the input off until every outstanding pixel has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_cases();
    send_pixel(16'h8000, 16'd32768, 16'd32768, 16'd12345);  // most negative hue
    send_pixel(16'hFFFF, 16'd20000, 16'd30000, 16'd32768);  // -1: black
    send_pixel(16'd0, 16'd32768, 16'd32768, 16'd32768);
    send_pixel(16'h7FFF, 16'd32768, 16'd32768, 16'd0);      // wraps to hue 0
    send_pixel(16'd23040, 16'd16384, 16'd32768, 16'd1000);  // exactly 360 degrees
    send_pixel(16'd23039, 16'd32768, 16'd32768, 16'd32768);
    send_pixel(16'd5000, 16'd0, 16'd20000, 16'd32768);      // gray
    send_pixel(16'd9000, 16'd32768, 16'd0, 16'd32768);      // black by value
    send_pixel(16'd13000, 16'hFFFF, 16'd25000, 16'd32768);  // saturation clipped
    send_pixel(16'd17000, 16'd12000, 16'hFFFF, 16'hFFFF);   // value and alpha clipped
    send_pixel(16'd1920, 16'd32769, 16'd32769, 16'd32769);
    send_pixel(16'd11520, 16'd1, 16'd1, 16'd1);
  endtask

  task automatic test_sector_boundaries();
    for (int k = 0; k < 6; k++) begin
      send_pixel(16'(k * SECTOR_UNITS), 16'($urandom_range(0, 32768)),
                 16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)));
      send_pixel(16'(k * SECTOR_UNITS + SECTOR_UNITS - 1), 16'd32768, 16'd32768,
                 16'($urandom_range(0, 32768)));
    end
  endtask

  task automatic test_random_pixels(int count);
    int              kind;
    logic [CH_W-1:0] h, s, v, a;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      h = 16'($urandom_range(0, FULL_TURN - 1));
      s = 16'($urandom_range(0, UNITY));
      v = 16'($urandom_range(0, UNITY));
      a = 16'($urandom_range(0, UNITY));
      if (kind >= 90) begin
        // raw 16-bit noise: negative hues, wrapped hues, over-range fields
        h = 16'($urandom);
        s = 16'($urandom);
        v = 16'($urandom);
        a = 16'($urandom);
      end else if (kind >= 80) begin
        s = $urandom_range(1) ? 16'(UNITY) : 16'd0;
        v = $urandom_range(1) ? 16'(UNITY) : 16'($urandom_range(0, 3));
      end
      send_pixel(h, s, v, a);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 26;
    recv_stall_pct = 55;
    test_special_cases();
    test_sector_boundaries();
    wait_drained();
    test_random_pixels(530);

    send_idle_pct = 55;
    recv_stall_pct = 26;
    test_random_pixels(530);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_pixels(540);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d pixels, checked %0d: negative and wrapped hues, all sector edges,",
             pixels_sent, pixels_checked);
    $display("clipped fields and random colors under input and output backpressure.");
    if (pixel_mismatches == 0 && expected_pixels.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
